FILE: design/svt_pkg.sv
// ----------------------------------------------------------------------------
// svt_pkg
// Shared types and constants for the sorted value table: command and status
// codes, field widths, and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package svt_pkg;

	localparam int DATA_W    = 32;
	localparam int CMD_W     = 2;
	localparam int POS_W     = 6;
	localparam int STAT_W    = 2;
	localparam int CNT_OUT_W = 7;
	localparam int DEPTH_DEF = 64;

	// tdata widths, rounded up to whole bytes
	localparam int S_DATA_W = ((DATA_W + POS_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((CNT_OUT_W + DATA_W + CNT_OUT_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_RANGE    = 2'd3
	} stat_t;

	// controller -> datapath operations
	typedef struct packed {
		logic  load;        // capture the accepted input beat
		logic  srch_init;   // lo = 0, hi = count
		logic  srch_upper;  // search mode on init: first entry > key
		logic  srch_rd;     // read the midpoint
		logic  srch_upd;    // narrow lo/hi with the read data
		logic  low_done;    // keep lower bound as run start
		logic  zero_rd;     // read entry 0
		logic  take_zero;   // remove only entry 0
		logic  take_run;    // remove run [p, lo)
		logic  ins_init;    // prepare upward move from insert point
		logic  mv_rd;       // read one entry to move
		logic  mv_wr;       // write the moved entry
		logic  put;         // write the inserted value
		logic  fin_del;     // commit the removal count
		logic  pos_rd;      // read entry at the requested position
		logic  set_status;
		stat_t status;
		logic  result_load; // load the result beat into the output register
	} svt_op_t;

	// datapath -> controller status
	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic empty;
		logic pos_ok;
		logic srch_end;
		logic srch_upper;
		logic zero_eq;
		logic run_empty;
		logic mv_done;
		logic out_free;
	} svt_flags_t;

endpackage

`default_nettype wire

FILE: design/svt_ram.sv
// ----------------------------------------------------------------------------
// svt_ram
// Generic RAM: one write port, one read port, registered read data that holds
// until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module svt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: design/svt_datapath.sv
// ----------------------------------------------------------------------------
// svt_datapath
// Entry memory, count, binary search bounds, move engine and the output
// register for the sorted value table.
// ----------------------------------------------------------------------------
`default_nettype none

module svt_datapath
	import svt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire svt_op_t             op,
	output svt_flags_t               flags,
	input  wire logic [S_DATA_W-1:0] s_tdata,
	input  wire logic [CMD_W-1:0]    s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,
	output logic [STAT_W-1:0]        m_tuser
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// latched item
	cmd_t               cmd_q;
	logic [DATA_W-1:0]  val_q;
	logic [POS_W-1:0]   pos_q;
	stat_t              status_q;
	logic [CW-1:0]      removed_q;

	// table state and working indexes
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      lo_q;
	logic [CW-1:0]      hi_q;
	logic [CW-1:0]      p_q;
	logic [CW-1:0]      r_q;
	logic [CW-1:0]      src_q;
	logic               upper_q;
	logic               dir_up_q;

	// output register
	logic               out_valid_q;
	stat_t              out_status_q;
	logic [CNT_OUT_W-1:0] out_count_q;
	logic [DATA_W-1:0]  out_rdval_q;
	logic [CNT_OUT_W-1:0] out_removed_q;

	// memory ports
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [DATA_W-1:0]  ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [DATA_W-1:0]  ram_rdata;

	// derived values
	logic [CW:0]        mid_sum;
	logic [CW-1:0]      mid;
	logic [CW-1:0]      src_m1;
	logic [CW-1:0]      src_mr;
	logic [CW+POS_W-1:0] pos_ext;
	logic [CW+POS_W-1:0] cnt_ext;
	logic               cond;
	logic               out_free;
	logic [CW+CNT_OUT_W-1:0] cnt_wide;
	logic [CW+CNT_OUT_W-1:0] rem_wide;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CW:1];
	assign src_m1  = src_q - CW'(1);
	assign src_mr  = src_q - r_q;
	assign pos_ext = {{CW{1'b0}}, pos_q};
	assign cnt_ext = {{POS_W{1'b0}}, count_q};
	assign cnt_wide = {{CNT_OUT_W{1'b0}}, count_q};
	assign rem_wide = {{CNT_OUT_W{1'b0}}, removed_q};

	// search predicate: first entry > key (upper) or >= key (lower)
	assign cond = upper_q ? ($signed(ram_rdata) >  $signed(val_q))
	                      : ($signed(ram_rdata) >= $signed(val_q));

	assign out_free = !out_valid_q || m_tready;

	// read address select
	always_comb begin
		logic [CW-1:0] ra;
		ra = '0;
		if (op.srch_rd) begin
			ra = mid;
		end else if (op.mv_rd) begin
			ra = dir_up_q ? src_m1 : src_q;
		end else if (op.pos_rd) begin
			ra = pos_ext[CW-1:0];
		end
		ram_raddr = ra[AW-1:0];
	end
	assign ram_re = op.srch_rd || op.mv_rd || op.pos_rd || op.zero_rd;

	// write address and data select
	always_comb begin
		logic [CW-1:0] wa;
		wa = dir_up_q ? src_q : src_mr;
		if (op.put) begin
			wa = p_q;
		end
		ram_waddr = wa[AW-1:0];
		ram_wdata = op.put ? val_q : ram_rdata;
	end
	assign ram_we = op.mv_wr || op.put;

	svt_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control state: count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (op.put) begin
				count_q <= count_q + CW'(1);
			end else if (op.fin_del) begin
				count_q <= count_q - r_q;
			end
			if (op.result_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item, search and move registers
	always_ff @(posedge clk) begin
		if (op.load) begin
			val_q     <= s_tdata[DATA_W-1:0];
			pos_q     <= s_tdata[DATA_W+POS_W-1:DATA_W];
			cmd_q     <= cmd_t'(s_tuser);
			status_q  <= ST_OK;
			removed_q <= '0;
		end
		if (op.set_status) begin
			status_q <= op.status;
		end
		if (op.fin_del) begin
			removed_q <= r_q;
		end

		// binary search bounds
		if (op.srch_init) begin
			lo_q    <= '0;
			hi_q    <= count_q;
			upper_q <= op.srch_upper;
		end else if (op.srch_upd) begin
			if (cond) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + CW'(1);
			end
		end
		if (op.low_done) begin
			p_q <= lo_q;
		end

		// move engine setup and stepping
		if (op.take_zero) begin
			p_q      <= '0;
			r_q      <= CW'(1);
			src_q    <= CW'(1);
			dir_up_q <= 1'b0;
		end else if (op.take_run) begin
			r_q      <= lo_q - p_q;
			src_q    <= lo_q;
			dir_up_q <= 1'b0;
		end else if (op.ins_init) begin
			p_q      <= lo_q;
			src_q    <= count_q;
			dir_up_q <= 1'b1;
		end else if (op.mv_wr) begin
			src_q <= dir_up_q ? src_m1 : src_q + CW'(1);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (op.result_load) begin
			out_status_q  <= status_q;
			out_count_q   <= cnt_wide[CNT_OUT_W-1:0];
			out_rdval_q   <= (cmd_q == CMD_READ && status_q == ST_OK) ? ram_rdata : '0;
			out_removed_q <= rem_wide[CNT_OUT_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(M_DATA_W - 2*CNT_OUT_W - DATA_W){1'b0}},
	                   out_removed_q, out_rdval_q, out_count_q};

	// flags to the controller
	always_comb begin
		flags.cmd        = cmd_q;
		flags.full       = (count_q == CW'(DEPTH));
		flags.empty      = (count_q == '0);
		flags.pos_ok     = (pos_ext < cnt_ext);
		flags.srch_end   = (lo_q == hi_q);
		flags.srch_upper = upper_q;
		flags.zero_eq    = (ram_rdata == val_q);
		flags.run_empty  = (lo_q == p_q);
		flags.mv_done    = dir_up_q ? (src_q == p_q) : (src_q == count_q);
		flags.out_free   = out_free;
	end

endmodule

`default_nettype wire

FILE: design/svt_ctrl.sv
// ----------------------------------------------------------------------------
// svt_ctrl
// Command sequencer for the sorted value table: dispatch, binary search,
// entry moves and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module svt_ctrl
	import svt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire svt_flags_t flags,
	output svt_op_t         op
);

	typedef enum logic [11:0] {
		S_IDLE     = 12'b000000000001,
		S_DISPATCH = 12'b000000000010,
		S_ZERO_RD  = 12'b000000000100,
		S_ZERO_CHK = 12'b000000001000,
		S_SRCH_RD  = 12'b000000010000,
		S_SRCH_CMP = 12'b000000100000,
		S_MOVE_RD  = 12'b000001000000,
		S_MOVE_WR  = 12'b000010000000,
		S_PUT      = 12'b000100000000,
		S_FIN_DEL  = 12'b001000000000,
		S_READ_RD  = 12'b010000000000,
		S_DONE     = 12'b100000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath operations
	always_comb begin
		state_d  = state_q;
		op       = '0;
		op.status = ST_OK;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					op.load = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (flags.cmd)
					CMD_INSERT: begin
						if (flags.full) begin
							op.set_status = 1'b1;
							op.status     = ST_FULL;
							state_d       = S_DONE;
						end else begin
							op.srch_init  = 1'b1;
							op.srch_upper = 1'b1;
							state_d       = S_SRCH_RD;
						end
					end
					CMD_DELETE: begin
						if (flags.empty) begin
							op.set_status = 1'b1;
							op.status     = ST_NOTFOUND;
							state_d       = S_DONE;
						end else begin
							state_d = S_ZERO_RD;
						end
					end
					CMD_READ: begin
						if (flags.pos_ok) begin
							state_d = S_READ_RD;
						end else begin
							op.set_status = 1'b1;
							op.status     = ST_RANGE;
							state_d       = S_DONE;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_ZERO_RD: begin
				op.zero_rd = 1'b1;
				state_d    = S_ZERO_CHK;
			end
			S_ZERO_CHK: begin
				// smallest entry equal to the key: drop just that one
				if (flags.zero_eq) begin
					op.take_zero = 1'b1;
					state_d      = S_MOVE_RD;
				end else begin
					op.srch_init  = 1'b1;
					op.srch_upper = 1'b0;
					state_d       = S_SRCH_RD;
				end
			end
			S_SRCH_RD: begin
				if (!flags.srch_end) begin
					op.srch_rd = 1'b1;
					state_d    = S_SRCH_CMP;
				end else if (flags.cmd == CMD_INSERT) begin
					op.ins_init = 1'b1;
					state_d     = S_MOVE_RD;
				end else if (!flags.srch_upper) begin
					// lower bound found, now find the end of the run
					op.low_done   = 1'b1;
					op.srch_init  = 1'b1;
					op.srch_upper = 1'b1;
					state_d       = S_SRCH_RD;
				end else if (flags.run_empty) begin
					op.set_status = 1'b1;
					op.status     = ST_NOTFOUND;
					state_d       = S_DONE;
				end else begin
					op.take_run = 1'b1;
					state_d     = S_MOVE_RD;
				end
			end
			S_SRCH_CMP: begin
				op.srch_upd = 1'b1;
				state_d     = S_SRCH_RD;
			end
			S_MOVE_RD: begin
				if (!flags.mv_done) begin
					op.mv_rd = 1'b1;
					state_d  = S_MOVE_WR;
				end else if (flags.cmd == CMD_INSERT) begin
					state_d = S_PUT;
				end else begin
					state_d = S_FIN_DEL;
				end
			end
			S_MOVE_WR: begin
				op.mv_wr = 1'b1;
				state_d  = S_MOVE_RD;
			end
			S_PUT: begin
				op.put  = 1'b1;
				state_d = S_DONE;
			end
			S_FIN_DEL: begin
				op.fin_del = 1'b1;
				state_d    = S_DONE;
			end
			S_READ_RD: begin
				op.pos_rd = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				// wait for room in the output register
				if (flags.out_free) begin
					op.result_load = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: design/sorted_value_table.sv
// ----------------------------------------------------------------------------
// sorted_value_table
// Bounded table of signed values kept in ascending order (duplicates allowed)
// with insert, delete and indexed read commands; one result beat per command.
//
//   channel  dir  tdata (low bit up)                         tuser
//   s_*      in   value[31:0], position[37:32]              command[1:0]
//   m_*      out  entry_count[6:0], read_value[38:7],       status[1:0]
//                 removed_count[45:39]
//
// One command at a time. Entries live in a 1R1W RAM; each binary search step is
// a midpoint read and a compare (S_SRCH_RD, S_SRCH_CMP), with S <= clog2(count+1)
// steps, and each entry moved is a read and a write (S_MOVE_RD, S_MOVE_WR).
// Full insert, empty delete, bad index and unused code go straight to the result.
// A delete whose smallest entry matches removes only that entry; else it runs a
// lower-bound search and an end-of-run search and removes the matching run, if any.
// Reset empties the table; RAM contents are not cleared. A result beat waits
// in the output register while the next command is accepted; a command that
// finishes while that register is still full holds until the beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_value_table
	import svt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,  // value, position
	input  wire logic [CMD_W-1:0]    s_tuser,  // command
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,  // entry_count, read_value, removed_count
	output logic [STAT_W-1:0]        m_tuser   // status
);

	svt_op_t    op;
	svt_flags_t flags;

	svt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.flags    (flags),
		.op       (op)
	);

	svt_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.flags    (flags),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire
